// File: rtl/core/dcu_pkg.sv
`default_nettype none

package dcu_pkg;

  // Largest channel count; sizes the request fields that travel between modules
  localparam int MAX_CHANNELS = 4;
  localparam int ROW_W        = 4;   // holds 3*MAX_CHANNELS rows and the sweep end
  localparam int CH_IDX_W     = 2;
  localparam int COPY_CH_W    = 2;
  localparam int CFG_IDX_W    = 4;

  // Opcodes
  localparam logic [2:0] OP_READ16  = 3'd0;
  localparam logic [2:0] OP_READ32  = 3'd1;
  localparam logic [2:0] OP_WRITE16 = 3'd2;
  localparam logic [2:0] OP_WRITE32 = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END  = 4'd1;
  localparam logic [31:0]          WINDOW_END_RESET = 32'd47;

  // Control register fields
  localparam int CTL_EN     = 15;
  localparam int CTL_TIM_HI = 13;
  localparam int CTL_TIM_LO = 12;
  localparam int CTL_WIDE   = 10;
  localparam int CTL_REPEAT = 9;
  localparam int CTL_SRC_HI = 8;
  localparam int CTL_SRC_LO = 7;
  localparam int CTL_DST_HI = 6;
  localparam int CTL_DST_LO = 5;

  localparam logic [1:0] TIM_IMMEDIATE = 2'd0;
  localparam logic [1:0] STEP_INC      = 2'd0;
  localparam logic [1:0] STEP_DEC      = 2'd1;
  localparam logic [1:0] STEP_FIXED    = 2'd2;
  localparam logic [1:0] STEP_INC_ALT  = 2'd3;

  localparam logic [31:0] STEP_WIDE   = 32'd4;
  localparam logic [31:0] STEP_NARROW = 32'd2;

  localparam logic [15:0] COUNT_WRAP      = 16'h3FFF;
  localparam logic [15:0] COUNT_WRAP_LONG = 16'hFFFF;
  localparam int          LONG_CHANNEL    = 3;
  localparam logic [15:0] EN_CLEAR_MASK   = 16'h7FFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] bus_address;
    logic [31:0] write_data;
  } dcu_item_t;

  typedef struct packed {
    logic                 hit;
    logic [31:0]          read_data;
    logic                 copy_valid;
    logic [31:0]          copy_source;
    logic [31:0]          copy_dest;
    logic                 copy_wide;
    logic [COPY_CH_W-1:0] copy_channel;
    logic                 copy_last;
  } dcu_result_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] count;
    logic [15:0] ctl;
  } dcu_work_t;

  // Visible register memory request: one row is a 32-bit pair of 16-bit registers
  typedef struct packed {
    logic             re;
    logic             we_lo;
    logic             we_hi;
    logic [ROW_W-1:0] row;
    logic [31:0]      wdata;
  } dcu_vreq_t;

  typedef struct packed {
    logic                re;
    logic                we;
    logic [CH_IDX_W-1:0] idx;
    dcu_work_t           wdata;
  } dcu_wreq_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_DATA,
    ST_LATCH,
    ST_TK_CALC,
    ST_TK_CLR
  } dcu_state_t;

endpackage

`default_nettype wire

// File: rtl/core/dcu_vis_mem.sv
`default_nettype none

module dcu_vis_mem
  import dcu_pkg::*;
#(
  parameter int ROWS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dcu_vreq_t   req,
  output logic [31:0]      rdata
);

  localparam int RW = $clog2(ROWS);

  logic [31:0]     mem [ROWS];
  logic [ROWS-1:0] vld_lo;
  logic [ROWS-1:0] vld_hi;
  logic [31:0]     rdata_raw;
  logic [1:0]      rvld;
  logic [RW-1:0]   addr;

  assign addr = req.row[RW-1:0];

  always_ff @(posedge clk) begin
    if (req.we_lo) begin
      mem[addr][15:0] <= req.wdata[15:0];
    end
    if (req.we_hi) begin
      mem[addr][31:16] <= req.wdata[31:16];
    end
    if (req.re) begin
      rdata_raw <= mem[addr];
    end
  end

  // Never-written halves read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_lo <= '0;
      vld_hi <= '0;
      rvld   <= '0;
    end else begin
      if (req.we_lo) begin
        vld_lo[addr] <= 1'b1;
      end
      if (req.we_hi) begin
        vld_hi[addr] <= 1'b1;
      end
      if (req.re) begin
        rvld <= {vld_hi[addr], vld_lo[addr]};
      end
    end
  end

  assign rdata = {rdata_raw[31:16] & {16{rvld[1]}}, rdata_raw[15:0] & {16{rvld[0]}}};

endmodule

`default_nettype wire

// File: rtl/core/dcu_work_mem.sv
`default_nettype none

module dcu_work_mem
  import dcu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire dcu_wreq_t req,
  output dcu_work_t      rdata
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dcu_work_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.idx[IW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.idx[IW-1:0]];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dcu_seq.sv
`default_nettype none

module dcu_seq
  import dcu_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire dcu_item_t   item,
  input  wire logic [31:0] window_base,
  input  wire logic [31:0] window_end,
  output dcu_vreq_t        vreq,
  input  wire logic [31:0] vrdata,
  output dcu_wreq_t        wreq,
  input  wire dcu_work_t   wrdata,
  output dcu_result_t      result,
  output logic             done
);

  localparam int NROWS = 3 * CHANNELS;
  localparam int NREGS = 6 * CHANNELS;
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  dcu_state_t state, state_next;

  logic [2:0]          op_q;
  logic [31:0]         data_q;
  logic                hit_q;
  logic [31:0]         off_q;
  logic [ROW_W-1:0]    cnt, cnt_next;
  logic [1:0]          pph, pph_next;
  logic [CW-1:0]       pch, pch_next;
  logic [31:0]         src_stg, src_stg_next;
  logic [31:0]         dst_stg, dst_stg_next;
  logic [CHANNELS-1:0] pending, pending_next;
  logic [CW-1:0]       tch, tch_next;
  dcu_result_t         res_next;
  logic                done_next;

  logic                wide_acc;
  logic [30:0]         h;
  logic                inrange;
  logic [ROW_W-1:0]    acc_row;
  logic [ROW_W-1:0]    tk_row;
  logic [CW-1:0]       top_ch;

  // Highest-numbered pending channel
  always_comb begin
    top_ch = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (pending[c]) begin
        top_ch = CW'(c);
      end
    end
  end

  assign wide_acc = op_q[0];
  assign h        = wide_acc ? {off_q[31:2], 1'b0} : off_q[31:1];
  assign inrange  = h < 31'(NREGS);
  assign acc_row  = h[ROW_W:1];
  assign tk_row   = ROW_W'(tch) + ROW_W'(tch) + ROW_W'(tch) + ROW_W'(2);
  assign busy     = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (op_q)
          OP_READ16, OP_READ32: state_next = (hit_q && inrange) ? ST_RD_DATA : ST_IDLE;
          OP_WRITE16, OP_WRITE32: state_next = hit_q ? ST_LATCH : ST_IDLE;
          OP_TICK: state_next = (|pending) ? ST_TK_CALC : ST_IDLE;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_RD_DATA: state_next = ST_IDLE;
      ST_LATCH: begin
        if (cnt == ROW_W'(NROWS)) begin
          state_next = ST_IDLE;
        end
      end
      ST_TK_CALC: begin
        if ((wrdata.count == 16'd1) && !wrdata.ctl[CTL_REPEAT]) begin
          state_next = ST_TK_CLR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_TK_CLR: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    logic [31:0] stepv;
    logic [1:0]  sctl;
    logic [1:0]  dctl;
    logic        last;
    logic [31:0] new_src;
    logic [31:0] new_dst;
    logic [15:0] new_count;
    logic [15:0] lctl;

    vreq         = '0;
    wreq         = '0;
    res_next     = '0;
    done_next    = 1'b0;
    cnt_next     = cnt;
    pph_next     = pph;
    pch_next     = pch;
    src_stg_next = src_stg;
    dst_stg_next = dst_stg;
    pending_next = pending;
    tch_next     = tch;

    stepv     = wrdata.ctl[CTL_WIDE] ? STEP_WIDE : STEP_NARROW;
    sctl      = wrdata.ctl[CTL_SRC_HI:CTL_SRC_LO];
    dctl      = wrdata.ctl[CTL_DST_HI:CTL_DST_LO];
    last      = 1'b0;
    new_src   = wrdata.src;
    new_dst   = wrdata.dst;
    new_count = wrdata.count - 16'd1;
    lctl      = vrdata[31:16];

    unique case (state)
      ST_IDLE: begin
      end
      ST_DECODE: begin
        cnt_next = '0;
        pph_next = '0;
        pch_next = '0;
        unique case (op_q)
          OP_READ16, OP_READ32: begin
            if (hit_q && inrange) begin
              vreq.re  = 1'b1;
              vreq.row = acc_row;
            end else begin
              res_next.hit = hit_q;
              done_next    = 1'b1;
            end
          end
          OP_WRITE16, OP_WRITE32: begin
            if (hit_q && inrange) begin
              vreq.row = acc_row;
              if (wide_acc) begin
                vreq.we_lo = 1'b1;
                vreq.we_hi = 1'b1;
                vreq.wdata = data_q;
              end else begin
                vreq.we_lo = !h[0];
                vreq.we_hi = h[0];
                vreq.wdata = {data_q[15:0], data_q[15:0]};
              end
            end
            if (!hit_q) begin
              done_next = 1'b1;
            end
          end
          OP_TICK: begin
            if (|pending) begin
              wreq.re  = 1'b1;
              wreq.idx = CH_IDX_W'(top_ch);
              tch_next = top_ch;
            end else begin
              done_next = 1'b1;
            end
          end
          default: done_next = 1'b1;
        endcase
      end
      ST_RD_DATA: begin
        res_next.hit = 1'b1;
        if (wide_acc) begin
          res_next.read_data = vrdata;
        end else begin
          res_next.read_data = {16'd0, h[0] ? vrdata[31:16] : vrdata[15:0]};
        end
        done_next = 1'b1;
      end
      ST_LATCH: begin
        // Sweep: issue row cnt, consume the row issued in the previous cycle
        if (cnt < ROW_W'(NROWS)) begin
          vreq.re  = 1'b1;
          vreq.row = cnt;
          cnt_next = cnt + ROW_W'(1);
        end
        if (cnt != '0) begin
          unique case (pph)
            2'd0: begin
              src_stg_next = vrdata;
              pph_next     = 2'd1;
            end
            2'd1: begin
              dst_stg_next = vrdata;
              pph_next     = 2'd2;
            end
            default: begin
              if (lctl[CTL_EN] && (lctl[CTL_TIM_HI:CTL_TIM_LO] == TIM_IMMEDIATE)) begin
                wreq.we          = 1'b1;
                wreq.idx         = CH_IDX_W'(pch);
                wreq.wdata.src   = src_stg;
                wreq.wdata.dst   = dst_stg;
                wreq.wdata.count = vrdata[15:0];
                wreq.wdata.ctl   = lctl;
                pending_next[pch] = 1'b1;
              end
              pph_next = 2'd0;
              pch_next = pch + CW'(1);
            end
          endcase
        end
        if (cnt == ROW_W'(NROWS)) begin
          res_next.hit = 1'b1;
          done_next    = 1'b1;
        end
      end
      ST_TK_CALC: begin
        unique case (sctl)
          STEP_INC: new_src = wrdata.src + stepv;
          STEP_DEC: new_src = wrdata.src - stepv;
          default:  new_src = wrdata.src;
        endcase
        unique case (dctl)
          STEP_INC, STEP_INC_ALT: new_dst = wrdata.dst + stepv;
          STEP_DEC:               new_dst = wrdata.dst - stepv;
          default:                new_dst = wrdata.dst;
        endcase
        if (wrdata.count == 16'd0) begin
          new_count = (int'(tch) == LONG_CHANNEL) ? COUNT_WRAP_LONG : COUNT_WRAP;
        end else begin
          last = (wrdata.count == 16'd1);
        end
        wreq.we          = 1'b1;
        wreq.idx         = CH_IDX_W'(tch);
        wreq.wdata.src   = new_src;
        wreq.wdata.dst   = new_dst;
        wreq.wdata.count = new_count;
        wreq.wdata.ctl   = wrdata.ctl;
        if (last) begin
          pending_next[tch] = 1'b0;
          if (!wrdata.ctl[CTL_REPEAT]) begin
            vreq.re  = 1'b1;
            vreq.row = tk_row;
          end
        end
        res_next.copy_valid   = 1'b1;
        res_next.copy_source  = wrdata.src;
        res_next.copy_dest    = wrdata.dst;
        res_next.copy_wide    = wrdata.ctl[CTL_WIDE];
        res_next.copy_channel = COPY_CH_W'(tch);
        res_next.copy_last    = last;
        done_next             = 1'b1;
      end
      ST_TK_CLR: begin
        vreq.we_hi = 1'b1;
        vreq.row   = tk_row;
        vreq.wdata = {vrdata[31:16] & EN_CLEAR_MASK, 16'd0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      op_q   <= item.opcode;
      data_q <= item.write_data;
      hit_q  <= (item.bus_address >= window_base) && (item.bus_address <= window_end);
      off_q  <= item.bus_address - window_base;
    end
    cnt     <= cnt_next;
    pph     <= pph_next;
    pch     <= pch_next;
    src_stg <= src_stg_next;
    dst_stg <= dst_stg_next;
    tch     <= tch_next;
    result  <= res_next;
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !vreq.we_lo && !vreq.we_hi && !wreq.we)
    else $error("memory write while idle");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    done && result.copy_valid && result.copy_last |-> !pending[result.copy_channel[CW-1:0]])
    else $error("channel still pending after its last unit");

  a_copy_no_hit: assert property (@(posedge clk) disable iff (rst)
    done && result.copy_valid |-> !result.hit && (result.read_data == 32'd0))
    else $error("copy result carries register access fields");

endmodule

`default_nettype wire

// File: rtl/core/four_channel_dma_controller_unit.sv
`default_nettype none

// Four-channel DMA register file with a one-unit-per-tick copy engine. Issue an
// item by raising start while busy is low; the result appears on result for
// exactly one cycle with done high and cannot be held off, so capture it then.
// Steps from the accept edge to done: a read that lands on a register passes
// decode and the register read; a read or write that misses the window, a read
// past the registers, an idle tick and unused opcodes end in decode; a write
// that hits (also one past the registers) runs the trigger sweep that reads
// every visible register row once through the single port of the register
// memory; a tick that serves a channel decodes, then updates the working copy,
// and when its last unit clears the channel's enable bit, busy stays high
// through the done cycle, so the next item is taken in the cycle after it.
// Otherwise a new item may be accepted in the done cycle, as busy is low then.
// No clearing pass after reset: the first item may follow reset at once.
// Window configuration is written through cfg_valid/cfg_ready (always ready).
// Write it only while no item is in flight; the block does not enforce this.

module four_channel_dma_controller_unit
  import dcu_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire dcu_item_t            item,
  output dcu_result_t               result,
  output logic                      done,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  // Window registers; writes to unknown indexes are dropped
  logic [31:0] window_base;
  logic [31:0] window_end;

  dcu_vreq_t   vreq;
  logic [31:0] vrdata;
  dcu_wreq_t   wreq;
  dcu_work_t   wrdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= '0;
      window_end  <= WINDOW_END_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_BASE: window_base <= cfg_data;
        CFG_WINDOW_END:  window_end  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Visible registers: two 16-bit registers per row, three rows per channel
  // (source, destination, count/control)
  dcu_vis_mem #(
    .ROWS(3 * CHANNELS)
  ) u_vis_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (vreq),
    .rdata(vrdata)
  );

  // Working copies, one entry per channel; only read for pending channels
  dcu_work_mem #(
    .DEPTH(CHANNELS)
  ) u_work_mem (
    .clk  (clk),
    .req  (wreq),
    .rdata(wrdata)
  );

  // Sequencer: decode, trigger sweep, tick read-modify-write
  dcu_seq #(
    .CHANNELS(CHANNELS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .window_base(window_base),
    .window_end (window_end),
    .vreq       (vreq),
    .vrdata     (vrdata),
    .wreq       (wreq),
    .wrdata     (wrdata),
    .result     (result),
    .done       (done)
  );

endmodule

`default_nettype wire
